FILE: hw/rtl/ncbg_pkg.sv
// Shared types, constants and register indexes of the NV12 color bar generator.
package ncbg_pkg;

  localparam int DEF_BAR_WIDTH   = 96;
  localparam int DEF_BAND_HEIGHT = 135;
  localparam int DEF_MAX_WIDTH   = 4096;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int GEOM_W     = 13;
  localparam int LINE_W     = 12;
  localparam int SHIFT_W    = 3;
  localparam int PIX_W      = 8;
  localparam int NUM_COLORS = 6;
  localparam int NUM_SHIFTS = 8;

  localparam logic [GEOM_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_ZERO   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_ONE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_TWO    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_THREE  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_FOUR   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_FIVE   = 3'd7;

  localparam logic [GEOM_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [GEOM_W-1:0] RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [NUM_COLORS-1:0][CFG_DATA_W-1:0] RST_PALETTE = {
    24'd11692404, 24'd13069717, 24'd8435247,
    24'd12095862, 24'd5009271,  24'd11700137
  };

  typedef struct packed {
    logic [GEOM_W-1:0]                          width;
    logic [GEOM_W-1:0]                          height;
    logic [NUM_COLORS-1:0][CFG_DATA_W-1:0]      palette;
  } geom_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] frame_index;
    logic               restart;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_byte;
    logic             chroma_plane;
    logic             end_of_frame;
  } result_t;

endpackage

FILE: hw/rtl/ncbg_cfg.sv
// Configuration registers and effective frame geometry of the color bar generator.
module ncbg_cfg #(
  parameter int MAX_WIDTH = ncbg_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ncbg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ncbg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output ncbg_pkg::geom_t                     geom,
  output logic                                width_wr
);

  localparam logic [ncbg_pkg::GEOM_W-1:0] W_CAP =
    ncbg_pkg::GEOM_W'(MAX_WIDTH) & ~ncbg_pkg::GEOM_W'(1);

  logic [ncbg_pkg::GEOM_W-1:0] frame_width;
  logic [ncbg_pkg::GEOM_W-1:0] frame_height;
  logic [ncbg_pkg::NUM_COLORS-1:0][ncbg_pkg::CFG_DATA_W-1:0] palette;
  logic [ncbg_pkg::GEOM_W-1:0] w_even;
  logic [ncbg_pkg::GEOM_W-1:0] h_even;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ncbg_pkg::RST_FRAME_WIDTH;
      frame_height <= ncbg_pkg::RST_FRAME_HEIGHT;
      palette      <= ncbg_pkg::RST_PALETTE;
    end else if (cfg_we) begin
      case (cfg_addr)
        ncbg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_wdata[ncbg_pkg::GEOM_W-1:0];
        ncbg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_wdata[ncbg_pkg::GEOM_W-1:0];
        ncbg_pkg::REG_COLOR_ZERO:   palette[0]   <= cfg_wdata;
        ncbg_pkg::REG_COLOR_ONE:    palette[1]   <= cfg_wdata;
        ncbg_pkg::REG_COLOR_TWO:    palette[2]   <= cfg_wdata;
        ncbg_pkg::REG_COLOR_THREE:  palette[3]   <= cfg_wdata;
        ncbg_pkg::REG_COLOR_FOUR:   palette[4]   <= cfg_wdata;
        ncbg_pkg::REG_COLOR_FIVE:   palette[5]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign width_wr = cfg_we && (cfg_addr == ncbg_pkg::REG_FRAME_WIDTH);
  assign w_even   = {frame_width[ncbg_pkg::GEOM_W-1:1], 1'b0};
  assign h_even   = {frame_height[ncbg_pkg::GEOM_W-1:1], 1'b0};

  always_comb begin
    geom.palette = palette;
    if (w_even < ncbg_pkg::GEOM_W'(2)) begin
      geom.width = ncbg_pkg::GEOM_W'(2);
    end else if (w_even > W_CAP) begin
      geom.width = W_CAP;
    end else begin
      geom.width = w_even;
    end
    if (h_even < ncbg_pkg::GEOM_W'(2)) begin
      geom.height = ncbg_pkg::GEOM_W'(2);
    end else if (h_even > ncbg_pkg::MAX_HEIGHT) begin
      geom.height = ncbg_pkg::MAX_HEIGHT;
    end else begin
      geom.height = h_even;
    end
  end

endmodule

FILE: hw/rtl/ncbg_core.sv
// Frame counters, bar and band trackers, start table sequencer and byte selection.
module ncbg_core #(
  parameter int BAR_WIDTH   = ncbg_pkg::DEF_BAR_WIDTH,
  parameter int BAND_HEIGHT = ncbg_pkg::DEF_BAND_HEIGHT,
  parameter int MAX_WIDTH   = ncbg_pkg::DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  ncbg_pkg::geom_t   geom,
  input  logic              width_wr,
  input  logic              fire,
  input  ncbg_pkg::item_t   item,
  output ncbg_pkg::result_t result,
  output logic              busy
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int BOW = $clog2(BAR_WIDTH);
  localparam int BNW = $clog2(BAND_HEIGHT + 1);
  localparam int LW  = ncbg_pkg::LINE_W;
  localparam int GW  = ncbg_pkg::GEOM_W;
  localparam int SW  = ncbg_pkg::SHIFT_W;

  typedef struct packed {
    logic [CW-1:0]  col;
    logic [BOW-1:0] bar_off;
    logic [2:0]     bar_phase;
  } col_trk_t;

  typedef struct packed {
    logic [BNW-1:0] off;
    logic           odd;
  } band_t;

  typedef struct packed {
    col_trk_t c;
    band_t    b;
  } pos_t;

  typedef enum logic [2:0] {S_IDLE, S_TBL, S_LOAD, S_ROWS, S_COLS} seq_state_t;

  function automatic band_t band_step(band_t b);
    band_t r;
    r = b;
    if (b.off == BNW'(BAND_HEIGHT - 1)) begin
      r.off = '0;
      r.odd = ~b.odd;
    end else begin
      r.off = b.off + BNW'(1);
    end
    return r;
  endfunction

  function automatic pos_t pos_step(pos_t p, logic [GW-1:0] w);
    pos_t r;
    r = p;
    if (GW'(p.c.col) + GW'(1) >= w) begin
      r.c = '0;
      r.b = band_step(p.b);
    end else begin
      r.c.col = p.c.col + CW'(1);
      if (p.c.bar_off == BOW'(BAR_WIDTH - 1)) begin
        r.c.bar_off   = '0;
        r.c.bar_phase = (p.c.bar_phase == 3'd5) ? 3'd0 : p.c.bar_phase + 3'd1;
      end else begin
        r.c.bar_off = p.c.bar_off + BOW'(1);
      end
    end
    return r;
  endfunction

  seq_state_t     seq_state;
  pos_t           wp;
  logic [BOW-1:0] sub;
  logic [SW-1:0]  slot;
  logic [LW-1:0]  cnt;

  pos_t tbl_pos [ncbg_pkg::NUM_SHIFTS];

  logic          frame_active, frame_active_next;
  logic          in_chroma, in_chroma_next;
  logic [CW-1:0] out_column, out_column_next;
  logic [LW-1:0] out_line, out_line_next;
  logic [SW-1:0] latched_shift, latched_shift_next;
  logic          v_byte_next, v_byte_next_next;
  pos_t          cur, cur_next;
  band_t         row_band, row_band_next;
  pos_t          frm, frm_next;

  logic          start;
  pos_t          sp, p;
  band_t         rb, rb2;
  logic          chroma, vn;
  logic [CW-1:0] oc;
  logic [LW-1:0] ol;
  logic [3:0]    idx_sum;
  logic [2:0]    idx;
  logic [ncbg_pkg::CFG_DATA_W-1:0] entry;
  logic [GW-1:0] oc_inc, ol_inc;
  logic          row_end;

  always_comb begin
    start   = item.restart | ~frame_active;
    sp      = start ? tbl_pos[item.frame_index] : frm;
    p       = start ? sp : cur;
    rb      = start ? sp.b : row_band;
    chroma  = ~start & in_chroma;
    vn      = ~start & v_byte_next;
    oc      = start ? '0 : out_column;
    ol      = start ? '0 : out_line;
    idx_sum = {1'b0, p.c.bar_phase} + (p.b.odd ? 4'd3 : 4'd0);
    idx     = (idx_sum >= 4'd6) ? 3'(idx_sum - 4'd6) : idx_sum[2:0];
    entry   = geom.palette[idx];
    oc_inc  = GW'(oc) + GW'(1);
    ol_inc  = GW'(ol) + GW'(1);
    row_end = oc_inc >= geom.width;
    rb2     = band_step(band_step(rb));

    frame_active_next  = 1'b1;
    in_chroma_next     = chroma;
    out_column_next    = oc;
    out_line_next      = ol;
    latched_shift_next = start ? item.frame_index : latched_shift;
    v_byte_next_next   = vn;
    cur_next           = p;
    row_band_next      = rb;
    frm_next           = sp;
    result.chroma_plane = chroma;
    result.end_of_frame = 1'b0;
    result.pixel_byte   = entry[23:16];

    if (!chroma) begin
      if (row_end) begin
        out_column_next = '0;
        if (ol_inc >= geom.height) begin
          out_line_next    = '0;
          in_chroma_next   = 1'b1;
          v_byte_next_next = 1'b0;
          row_band_next    = sp.b;
          cur_next         = sp;
        end else begin
          out_line_next = ol_inc[LW-1:0];
          row_band_next = band_step(rb);
          cur_next      = {sp.c, band_step(rb)};
        end
      end else begin
        out_column_next = oc_inc[CW-1:0];
        cur_next        = pos_step(p, geom.width);
      end
    end else begin
      result.pixel_byte = vn ? entry[7:0] : entry[15:8];
      v_byte_next_next  = oc_inc[0];
      if (row_end) begin
        out_column_next  = '0;
        v_byte_next_next = 1'b0;
        if (ol_inc >= (geom.height >> 1)) begin
          result.end_of_frame = 1'b1;
          frame_active_next   = 1'b0;
          in_chroma_next      = 1'b0;
          out_line_next       = '0;
        end else begin
          out_line_next = ol_inc[LW-1:0];
          row_band_next = rb2;
          cur_next      = {sp.c, rb2};
        end
      end else begin
        out_column_next = oc_inc[CW-1:0];
        if (oc[0]) begin
          cur_next = pos_step(pos_step(p, geom.width), geom.width);
        end
      end
    end
  end

  assign busy = (seq_state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state     <= S_TBL;
      wp            <= '0;
      sub           <= '0;
      slot          <= '0;
      cnt           <= '0;
      frame_active  <= 1'b0;
      in_chroma     <= 1'b0;
      out_column    <= '0;
      out_line      <= '0;
      latched_shift <= '0;
      v_byte_next   <= 1'b0;
    end else begin
      if (fire) begin
        frame_active  <= frame_active_next;
        in_chroma     <= in_chroma_next;
        out_column    <= out_column_next;
        out_line      <= out_line_next;
        latched_shift <= latched_shift_next;
        v_byte_next   <= v_byte_next_next;
        cur           <= cur_next;
        row_band      <= row_band_next;
        frm           <= frm_next;
      end
      case (seq_state)
        S_IDLE: ;
        S_TBL: begin
          if (sub == '0) begin
            tbl_pos[slot] <= wp;
            if (slot == latched_shift) begin
              frm <= wp;
            end
          end
          if (sub == '0 && slot == SW'(ncbg_pkg::NUM_SHIFTS - 1)) begin
            seq_state <= frame_active ? S_LOAD : S_IDLE;
          end else begin
            wp <= pos_step(wp, geom.width);
            if (sub == BOW'(BAR_WIDTH - 1)) begin
              sub  <= '0;
              slot <= slot + SW'(1);
            end else begin
              sub <= sub + BOW'(1);
            end
          end
        end
        S_LOAD: begin
          wp        <= frm;
          cnt       <= in_chroma ? {out_line[LW-2:0], 1'b0} : out_line;
          seq_state <= S_ROWS;
        end
        S_ROWS: begin
          if (cnt == '0) begin
            row_band  <= wp.b;
            cnt       <= in_chroma ? LW'({out_column[CW-1:1], 1'b0}) : LW'(out_column);
            seq_state <= S_COLS;
          end else begin
            wp.b <= band_step(wp.b);
            cnt  <= cnt - LW'(1);
          end
        end
        S_COLS: begin
          if (cnt == '0) begin
            cur       <= wp;
            seq_state <= S_IDLE;
          end else begin
            wp  <= pos_step(wp, geom.width);
            cnt <= cnt - LW'(1);
          end
        end
        default: seq_state <= S_IDLE;
      endcase
      if (width_wr) begin
        seq_state <= S_TBL;
        wp        <= '0;
        sub       <= '0;
        slot      <= '0;
      end
    end
  end

  a_no_item_while_busy: assert property (@(posedge clk) disable iff (rst)
    fire |-> (seq_state == S_IDLE))
    else $error("item processed while trackers are rebuilt");

  a_width_write_stalls: assert property (@(posedge clk) disable iff (rst)
    width_wr |=> busy)
    else $error("width write did not start a tracker rebuild");

  a_eof_closes_frame: assert property (@(posedge clk) disable iff (rst)
    (fire && result.end_of_frame) |=> !frame_active)
    else $error("frame still active after its last byte");

  a_v_only_in_chroma: assert property (@(posedge clk) disable iff (rst)
    v_byte_next |-> in_chroma)
    else $error("V byte pending outside the chroma plane");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    (frame_active && !busy) |-> (cur.c.bar_phase <= 3'd5))
    else $error("bar phase out of range");

endmodule

FILE: hw/rtl/nv12_color_bar_generator_top.sv
// Top level of the NV12 color bar generator: stream handshake, item and result registers.
// Each accepted item yields one byte; the item is held in the item register until the result register takes its result.
// Throughput is one item per cycle, limited by backpressure on the result side and by start table rebuilds.
// After reset, and after every write of the frame width, the start table is rebuilt with
// s_axis_tready low; within a frame the trackers are then replayed line by line and then
// byte by byte to the current position. Reset clears the frame counters and flags.
module nv12_color_bar_generator_top #(
  parameter int BAR_WIDTH   = ncbg_pkg::DEF_BAR_WIDTH,
  parameter int BAND_HEIGHT = ncbg_pkg::DEF_BAND_HEIGHT,
  parameter int MAX_WIDTH   = ncbg_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ncbg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ncbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // frame_index[2:0], restart[3]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // pixel_byte[7:0]
  output logic                            m_axis_tuser,  // chroma_plane
  output logic                            m_axis_tlast
);

  ncbg_pkg::geom_t   geom;
  ncbg_pkg::item_t   in_item;
  ncbg_pkg::result_t core_result;
  ncbg_pkg::result_t out_result;
  logic              width_wr;
  logic              busy;
  logic              in_valid;
  logic              adv;
  logic              fire;

  ncbg_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .width_wr  (width_wr)
  );

  ncbg_core #(
    .BAR_WIDTH   (BAR_WIDTH),
    .BAND_HEIGHT (BAND_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .width_wr (width_wr),
    .fire     (fire),
    .item     (in_item),
    .result   (core_result),
    .busy     (busy)
  );

  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign fire          = in_valid & adv;
  assign s_axis_tready = ~rst & ~busy & (~in_valid | adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
        in_item  <= {s_axis_tdata[2:0], s_axis_tdata[3]};
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        m_axis_tvalid <= 1'b1;
        out_result    <= core_result;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = out_result.pixel_byte;
  assign m_axis_tuser = out_result.chroma_plane;
  assign m_axis_tlast = out_result.end_of_frame;

endmodule

FILE: verif/nv12_color_bar_generator_checker.sv
`timescale 1ns / 1ps
// Stream checker of the NV12 color bar generator: predicts every byte and compares it.
module nv12_color_bar_generator_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ncbg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ncbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // frame_index[2:0], restart[3]
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [7:0]                      m_axis_tdata,  // pixel_byte[7:0]
  input  logic                            m_axis_tuser,  // chroma_plane
  input  logic                            m_axis_tlast,
  output int                              mismatches,
  output int                              pending
);
  import ncbg_pkg::*;

  localparam int BAR  = DEF_BAR_WIDTH;
  localparam int BAND = DEF_BAND_HEIGHT;

  logic [GEOM_W-1:0]     width_reg;
  logic [GEOM_W-1:0]     height_reg;
  logic [CFG_DATA_W-1:0] colors [NUM_COLORS];
  logic                  frame_on;
  logic                  chroma_now;
  logic                  v_next;
  logic [GEOM_W-1:0]     col_cnt;
  logic [GEOM_W-1:0]     row_cnt;
  logic [SHIFT_W-1:0]    bar_shift;
  result_t               expected_bytes [$];
  result_t               seen;
  result_t               want;

  initial mismatches = 0;
  initial pending = 0;

  function automatic logic [CFG_DATA_W-1:0] bar_color(int unsigned k, int unsigned w);
    int unsigned shifted;
    int unsigned pick;
    shifted = k + 32'(bar_shift) * BAR;
    pick = ((shifted % w) / BAR + (((shifted / w) / BAND) & 1) * 3) % 6;
    return colors[pick];
  endfunction

  function automatic result_t predict_byte(logic [SHIFT_W-1:0] index, logic restart);
    result_t               r;
    logic [GEOM_W-1:0]     w;
    logic [GEOM_W-1:0]     h;
    logic [CFG_DATA_W-1:0] c;
    w = width_reg & 13'h1FFE;
    if (w < 2) w = 2;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    h = height_reg & 13'h1FFE;
    if (h < 2) h = 2;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (restart || !frame_on) begin
      bar_shift  = index;
      frame_on   = 1'b1;
      chroma_now = 1'b0;
      col_cnt    = '0;
      row_cnt    = '0;
      v_next     = 1'b0;
    end
    r = '0;
    if (!chroma_now) begin
      c = bar_color(32'(row_cnt) * 32'(w) + 32'(col_cnt), 32'(w));
      r.pixel_byte = c[23:16];
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = '0;
        row_cnt++;
        if (row_cnt >= h) begin
          row_cnt    = '0;
          chroma_now = 1'b1;
          v_next     = 1'b0;
        end
      end
    end else begin
      c = bar_color(2 * 32'(row_cnt) * 32'(w) + 32'(col_cnt & ~13'd1), 32'(w));
      r.pixel_byte   = v_next ? c[7:0] : c[15:8];
      r.chroma_plane = 1'b1;
      col_cnt++;
      v_next = col_cnt[0];
      if (col_cnt >= w) begin
        col_cnt = '0;
        v_next  = 1'b0;
        row_cnt++;
        if (row_cnt >= h / 2) begin
          r.end_of_frame = 1'b1;
          frame_on       = 1'b0;
          chroma_now     = 1'b0;
          row_cnt        = '0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      for (int i = 0; i < NUM_COLORS; i++) colors[i] = RST_PALETTE[i];
      frame_on   = 1'b0;
      chroma_now = 1'b0;
      v_next     = 1'b0;
      col_cnt    = '0;
      row_cnt    = '0;
      bar_shift  = '0;
      expected_bytes.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_wdata[GEOM_W-1:0];
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_wdata[GEOM_W-1:0];
          end
          default: begin
            colors[cfg_addr - REG_COLOR_ZERO] = cfg_wdata;
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{pixel_byte: m_axis_tdata, chroma_plane: m_axis_tuser,
                 end_of_frame: m_axis_tlast};
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected item: byte %02h plane %0b last %0b",
                     seen.pixel_byte, seen.chroma_plane, seen.end_of_frame);
        end else begin
          want = expected_bytes.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected byte %02h plane %0b last %0b, got byte %02h plane %0b last %0b",
                       want.pixel_byte, want.chroma_plane, want.end_of_frame,
                       seen.pixel_byte, seen.chroma_plane, seen.end_of_frame);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_bytes.push_back(predict_byte(s_axis_tdata[2:0], s_axis_tdata[3]));
      pending <= expected_bytes.size();
    end
  end

endmodule

FILE: verif/nv12_color_bar_generator_top_test.sv
`timescale 1ns / 1ps
// Test top of the NV12 color bar generator: register writes, item stimulus and the verdict.
module nv12_color_bar_generator_top_test;
  import ncbg_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [NUM_COLORS-1:0][CFG_DATA_W-1:0] EXTREME_COLORS = {
    24'hF0F0F0, 24'h0F0F0F, 24'h00FF00, 24'hFF00FF, 24'hFFFFFF, 24'h000000
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;  // frame_index[2:0], restart[3]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;  // pixel_byte[7:0]
  logic                  m_axis_tuser;  // chroma_plane
  logic                  m_axis_tlast;
  int                    mismatches;
  int                    pending;
  bit                    steady = 1'b0;
  int                    stall_left = 0;
  int                    stall_roll;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nv12_color_bar_generator_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  nv12_color_bar_generator_checker stream_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_roll = $urandom_range(99);
      if (stall_roll < 12) stall_left <= $urandom_range(1, 3);
      else if (stall_roll < 15) stall_left <= $urandom_range(8, 16);
    end
  end

  function automatic int idle_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 16);
  endfunction

  function automatic int frame_bytes(logic [GEOM_W-1:0] w, logic [GEOM_W-1:0] h);
    return int'(w & 13'h1FFE) * int'(h & 13'h1FFE) * 3 / 2;
  endfunction

  task automatic send_item(logic [SHIFT_W-1:0] index, logic restart);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, restart, index};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_run(int count, int restart_odds, logic first_restart);
    for (int i = 0; i < count; i++)
      send_item(SHIFT_W'($urandom_range(NUM_SHIFTS - 1)),
                (i == 0) ? first_restart
                         : (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0));
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Colors: 0 keeps the palette, 1 writes the extreme set, 2 writes random entries.
  task automatic program_frame(logic [GEOM_W-1:0] w, logic [GEOM_W-1:0] h, int palette_mode);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    if (palette_mode != 0)
      for (int i = 0; i < NUM_COLORS; i++)
        write_reg(REG_COLOR_ZERO + CFG_ADDR_W'(i),
                  (palette_mode == 1) ? EXTREME_COLORS[i] : CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int w;
    int h;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(3'd3, 1'b0);
    send_item(3'd6, 1'b0);
    send_item(3'd1, 1'b1);
    program_frame(13'd769, 13'd3, 1);
    for (int i = 0; i < NUM_SHIFTS; i++) send_item(SHIFT_W'(i), 1'b1);
    for (int i = NUM_SHIFTS - 1; i >= 0; i--) send_item(SHIFT_W'(i), 1'b0);
    send_item(3'd7, 1'b1);
    send_item(3'd0, 1'b0);
    send_item(3'd2, 1'b1);

    program_frame(13'd4096, 13'd4096, 2);
    send_run(4096 + 1000, 0, 1'b1);
    program_frame(13'd768, 13'd2, 0);
    send_run(2304 + $urandom_range(800), 0, 1'b0);
    program_frame(13'($urandom_range(768, 4096)), 13'($urandom_range(2, 4096)), 2);
    send_run(400, 6, 1'b1);
    for (int p = 0; p < 4; p++) begin
      w = (p == 0) ? 768 : (p == 1) ? 769 : $urandom_range(768, 1100);
      h = $urandom_range(2, 6);
      steady = (p == 2);
      program_frame(13'(w), 13'(h), (p == 3) ? 2 : 0);
      send_run(frame_bytes(13'(w), 13'(h)) + $urandom_range(400), 0, 1'($urandom_range(1)));
    end
    steady = 1'b1;
    program_frame(13'd768, 13'd138, 2);
    send_run(frame_bytes(13'd768, 13'd138) + 20, 0, 1'b1);
    steady = 1'b0;
    program_frame(13'd4095, 13'd4096, 2);
    send_run(300, 3, 1'b1);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
